@@ hdl/sje_pkg.sv @@
// ----------------------------------------------------------------------------
// sje_pkg
// Shared types, constants and saturation helpers of the 3x3 symmetric
// Jacobi eigen-solver.
// ----------------------------------------------------------------------------
package sje_pkg;

  localparam int SJE_SWEEPS = 12;

  // Working word of the matrix and eigenvector store.
  localparam int MW = 42;

  // Nine matrix entries, then nine eigenvector entries.
  localparam int RAM_DEPTH = 18;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int VEC_BASE  = 9;

  localparam logic signed [MW-1:0] ONE_Q30 = 42'sh000_4000_0000;
  localparam logic signed [63:0]   MAT_LIM = 64'sh0000_0100_0000_0000;
  localparam logic signed [63:0]   VEC_LIM = 64'sh0000_0001_0000_0000;
  localparam logic signed [MW-1:0] EIG_MAX = 42'sd2147483647;
  localparam logic signed [MW-1:0] EIG_MIN = -42'sd2147483648;
  localparam logic signed [MW-1:0] OUT_LIM = 42'sd1073741824;

  typedef enum logic {
    DS_SQRT,
    DS_DIV
  } ds_op_e;

  typedef struct packed {
    logic   start;
    ds_op_e op;
  } ds_req_t;

  function automatic logic signed [MW-1:0] sat_w(input logic signed [63:0] x,
                                                 input logic vec);
    logic signed [63:0] lim;
    lim = vec ? VEC_LIM : MAT_LIM;
    if (x > lim) begin
      return lim[MW-1:0];
    end else if (x < -lim) begin
      return -lim[MW-1:0];
    end
    return x[MW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_eig(input logic signed [MW-1:0] x);
    if (x > EIG_MAX) begin
      return EIG_MAX[31:0];
    end else if (x < EIG_MIN) begin
      return EIG_MIN[31:0];
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat_vec(input logic signed [MW-1:0] x);
    if (x > OUT_LIM) begin
      return OUT_LIM[31:0];
    end else if (x < -OUT_LIM) begin
      return -OUT_LIM[31:0];
    end
    return x[31:0];
  endfunction

endpackage

@@ hdl/sym3_jacobi_eigen.sv @@
// ----------------------------------------------------------------------------
// sym3_jacobi_eigen
// Cyclic Jacobi eigen-decomposition of a symmetric 3x3 matrix in fixed point.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Fields
//  command   in         start / busy   a_00 a_01 a_02 a_11 a_12 a_22 (Q8.24)
//  result    out        done_o strobe  eig_low/mid/high (Q8.24), vec0..2 (Q2.30)
//
// An item is taken when start is high and busy is low; busy stays high through
// the done_o strobe. Before the strobe the solver runs up to 3*SWEEPS rotations,
// skipping a rotation whose pivot entry is zero and stopping early once every
// off-diagonal entry is zero; the shared divide/square-root unit (64 and 32
// iterations) takes most of that time.
// Reset returns the sequencer to idle at once; the result cannot be held off.
// ----------------------------------------------------------------------------
module sym3_jacobi_eigen import sje_pkg::*; #(
  parameter int SWEEPS = SJE_SWEEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] a_00_i,
  input  logic signed [31:0] a_01_i,
  input  logic signed [31:0] a_02_i,
  input  logic signed [31:0] a_11_i,
  input  logic signed [31:0] a_12_i,
  input  logic signed [31:0] a_22_i,
  output logic               done_o,
  output logic signed [31:0] eig_low_o,
  output logic signed [31:0] eig_mid_o,
  output logic signed [31:0] eig_high_o,
  output logic signed [31:0] vec0_x_o,
  output logic signed [31:0] vec0_y_o,
  output logic signed [31:0] vec0_z_o,
  output logic signed [31:0] vec1_x_o,
  output logic signed [31:0] vec1_y_o,
  output logic signed [31:0] vec1_z_o,
  output logic signed [31:0] vec2_x_o,
  output logic signed [31:0] vec2_y_o,
  output logic signed [31:0] vec2_z_o
);

  localparam int SWW = $clog2(SWEEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_CK0, S_CK1, S_CK2, S_PV0, S_PV1, S_PV2, S_SCL,
    S_SQ0, S_SQ1, S_SQ2, S_RT1, S_DV1, S_TT0, S_TT1, S_RT2, S_DV2,
    S_SC0, S_SC1, S_UPD, S_NXT, S_SR0, S_SR1, S_SR2, S_BS, S_VR, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PS_COL,
    PS_ROW,
    PS_VEC
  } pass_e;

  state_e               state_q;
  logic [4:0]           cnt_q;
  logic [SWW-1:0]       sweep_q;
  logic [1:0]           k_q;
  pass_e                pass_q;
  logic [1:0]           i_q;
  logic [2:0]           ph_q;
  logic [1:0]           bs_q;
  logic [1:0]           vj_q;
  logic [1:0]           vk_q;
  logic signed [MW-1:0] in_q [6];
  logic                 nz_q;
  logic signed [MW-1:0] apq_q;
  logic signed [MW-1:0] aqq_q;
  logic [42:0]          md_q;
  logic [42:0]          me_q;
  logic                 tneg_q;
  logic [63:0]          acc_q;
  logic [30:0]          mt_q;
  logic signed [32:0]   c_q;
  logic signed [32:0]   s_q;
  logic signed [MW-1:0] xp_q;
  logic signed [MW-1:0] xq_q;
  logic signed [63:0]   pa_q;
  logic signed [MW-1:0] w0_q, w1_q, w2_q;
  logic [1:0]           pm0_q, pm1_q, pm2_q;
  logic signed [31:0]   vec_q [3][3];
  logic signed [31:0]   eig_q [3];
  logic                 done_q;

  logic [1:0]           piv_p, piv_q;
  logic [RAM_AW-1:0]    ra, rb, wa;
  logic [RAM_AW-1:0]    upd_pa, upd_qa;
  logic                 we;
  logic signed [MW-1:0] wd;
  logic [MW-1:0]        rd_a_raw, rd_b_raw;
  logic signed [MW-1:0] rd_a, rd_b;
  logic signed [MW-1:0] mul_x;
  logic signed [32:0]   mul_y;
  logic                 mul_raw;
  logic signed [63:0]   mul_res;
  ds_req_t              ds_req;
  logic [63:0]          ds_a, ds_b;
  logic                 ds_done;
  logic [63:0]          ds_res;
  logic [32:0]          den;
  logic signed [42:0]   dd, ee;
  logic signed [MW-1:0] load_val;
  logic [1:0]           vcol;
  logic                 bs_swap;

  function automatic logic [RAM_AW-1:0] maddr(input logic [1:0] r, input logic [1:0] c,
                                              input logic vb);
    logic [RAM_AW-1:0] base;
    base = vb ? RAM_AW'(VEC_BASE) : '0;
    return base + RAM_AW'(r) * RAM_AW'(3) + RAM_AW'(c);
  endfunction

  assign rd_a = $signed(rd_a_raw);
  assign rd_b = $signed(rd_b_raw);

  always_comb begin
    unique case (k_q)
      2'd0:    begin piv_p = 2'd0; piv_q = 2'd1; end
      2'd1:    begin piv_p = 2'd0; piv_q = 2'd2; end
      default: begin piv_p = 2'd1; piv_q = 2'd2; end
    endcase
  end

  always_comb begin
    unique case (pass_q)
      PS_COL: begin
        upd_pa = maddr(i_q, piv_p, 1'b0);
        upd_qa = maddr(i_q, piv_q, 1'b0);
      end
      PS_ROW: begin
        upd_pa = maddr(piv_p, i_q, 1'b0);
        upd_qa = maddr(piv_q, i_q, 1'b0);
      end
      default: begin
        upd_pa = maddr(i_q, piv_p, 1'b1);
        upd_qa = maddr(i_q, piv_q, 1'b1);
      end
    endcase
  end

  always_comb begin
    unique case (cnt_q)
      5'd0:                load_val = in_q[0];
      5'd1, 5'd3:          load_val = in_q[1];
      5'd2, 5'd6:          load_val = in_q[2];
      5'd4:                load_val = in_q[3];
      5'd5, 5'd7:          load_val = in_q[4];
      5'd8:                load_val = in_q[5];
      5'd9, 5'd13, 5'd17:  load_val = ONE_Q30;
      default:             load_val = '0;
    endcase
  end

  always_comb begin
    unique case (vj_q)
      2'd0:    vcol = pm0_q;
      2'd1:    vcol = pm1_q;
      default: vcol = pm2_q;
    endcase
  end

  assign dd      = 43'(aqq_q) - 43'(rd_a);
  assign ee      = 43'(apq_q) <<< 1;
  assign den     = {1'b0, md_q[31:0]} + {1'b0, ds_res[31:0]};
  assign bs_swap = (bs_q == 2'd1) ? (w1_q > w2_q) : (w0_q > w1_q);

  always_comb begin
    ra      = '0;
    rb      = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = '0;
    mul_x   = '0;
    mul_y   = '0;
    mul_raw = 1'b0;
    ds_req  = '{start: 1'b0, op: DS_SQRT};
    ds_a    = '0;
    ds_b    = '0;
    unique case (state_q)
      S_LOAD: begin
        we = 1'b1;
        wa = cnt_q;
        wd = load_val;
      end
      S_CK0: begin
        ra = maddr(2'd0, 2'd1, 1'b0);
        rb = maddr(2'd0, 2'd2, 1'b0);
      end
      S_CK1: ra = maddr(2'd1, 2'd2, 1'b0);
      S_PV0: begin
        ra = maddr(piv_p, piv_q, 1'b0);
        rb = maddr(piv_q, piv_q, 1'b0);
      end
      S_PV1: ra = maddr(piv_p, piv_p, 1'b0);
      S_SQ0: begin
        mul_x   = MW'(md_q[30:0]);
        mul_y   = {2'b0, md_q[30:0]};
        mul_raw = 1'b1;
      end
      S_SQ1: begin
        mul_x   = MW'(me_q[30:0]);
        mul_y   = {2'b0, me_q[30:0]};
        mul_raw = 1'b1;
      end
      S_SQ2: begin
        ds_req = '{start: 1'b1, op: DS_SQRT};
        ds_a   = acc_q + 64'(mul_res);
      end
      S_RT1: begin
        if (ds_done && den != '0) begin
          ds_req = '{start: 1'b1, op: DS_DIV};
          ds_a   = ({33'b0, me_q[30:0]} << 30) + 64'(den >> 1);
          ds_b   = 64'(den);
        end
      end
      S_TT0: begin
        mul_x   = MW'(mt_q);
        mul_y   = {2'b0, mt_q};
        mul_raw = 1'b1;
      end
      S_TT1: begin
        ds_req = '{start: 1'b1, op: DS_SQRT};
        ds_a   = 64'(mul_res) + 64'h1000_0000_0000_0000;
      end
      S_RT2: begin
        if (ds_done) begin
          ds_req = '{start: 1'b1, op: DS_DIV};
          ds_a   = 64'h1000_0000_0000_0000 + (ds_res >> 1);
          ds_b   = ds_res;
        end
      end
      S_SC0: begin
        mul_x = tneg_q ? -$signed(MW'(mt_q)) : $signed(MW'(mt_q));
        mul_y = c_q;
      end
      S_UPD: begin
        unique case (ph_q)
          3'd0: begin
            ra = upd_pa;
            rb = upd_qa;
          end
          3'd2: begin
            mul_x = xp_q;
            mul_y = c_q;
          end
          3'd3: begin
            mul_x = xq_q;
            mul_y = s_q;
          end
          3'd4: begin
            mul_x = xp_q;
            mul_y = s_q;
            we    = 1'b1;
            wa    = upd_pa;
            wd    = sat_w(pa_q - mul_res, pass_q == PS_VEC);
          end
          3'd5: begin
            mul_x = xq_q;
            mul_y = c_q;
          end
          3'd6: begin
            we = 1'b1;
            wa = upd_qa;
            wd = sat_w(pa_q + mul_res, pass_q == PS_VEC);
          end
          default: ;
        endcase
      end
      S_SR0: begin
        ra = maddr(2'd0, 2'd0, 1'b0);
        rb = maddr(2'd1, 2'd1, 1'b0);
      end
      S_SR1: ra = maddr(2'd2, 2'd2, 1'b0);
      S_VR:  ra = maddr(vk_q, vcol, 1'b1);
      default: ;
    endcase
  end

  sje_ram #(
    .W (MW),
    .D (RAM_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wa),
    .wdata_i   (wd),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (rd_a_raw),
    .rdata_b_o (rd_b_raw)
  );

  sje_mul u_mul (
    .clk_i (clk_i),
    .x_i   (mul_x),
    .y_i   (mul_y),
    .raw_i (mul_raw),
    .res_o (mul_res)
  );

  sje_divsqrt u_ds (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ds_req),
    .a_i    (ds_a),
    .b_i    (ds_b),
    .done_o (ds_done),
    .res_o  (ds_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sweep_q <= '0;
      k_q     <= '0;
      pass_q  <= PS_COL;
      i_q     <= '0;
      ph_q    <= '0;
      bs_q    <= '0;
      vj_q    <= '0;
      vk_q    <= '0;
      done_q  <= 1'b0;
      eig_q   <= '{default: '0};
      vec_q   <= '{default: '0};
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            cnt_q   <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (cnt_q == 5'(RAM_DEPTH - 1)) begin
            sweep_q <= '0;
            state_q <= S_CK0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_CK0: state_q <= S_CK1;
        S_CK1: state_q <= S_CK2;
        S_CK2: begin
          if (!nz_q && rd_a == '0) begin
            state_q <= S_SR0;
          end else begin
            k_q     <= '0;
            state_q <= S_PV0;
          end
        end
        S_PV0: state_q <= S_PV1;
        S_PV1: state_q <= S_PV2;
        S_PV2: state_q <= (apq_q == '0) ? S_NXT : S_SCL;
        S_SCL: begin
          if (md_q[42:31] == '0 && me_q[42:31] == '0) begin
            state_q <= S_SQ0;
          end
        end
        S_SQ0: state_q <= S_SQ1;
        S_SQ1: state_q <= S_SQ2;
        S_SQ2: state_q <= S_RT1;
        S_RT1: begin
          if (ds_done) begin
            state_q <= (den == '0) ? S_TT0 : S_DV1;
          end
        end
        S_DV1: begin
          if (ds_done) begin
            state_q <= S_TT0;
          end
        end
        S_TT0: state_q <= S_TT1;
        S_TT1: state_q <= S_RT2;
        S_RT2: begin
          if (ds_done) begin
            state_q <= S_DV2;
          end
        end
        S_DV2: begin
          if (ds_done) begin
            state_q <= S_SC0;
          end
        end
        S_SC0: state_q <= S_SC1;
        S_SC1: begin
          pass_q  <= PS_COL;
          i_q     <= '0;
          ph_q    <= '0;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (ph_q == 3'd6) begin
            ph_q <= '0;
            if (i_q == 2'd2) begin
              i_q <= '0;
              unique case (pass_q)
                PS_COL:  pass_q <= PS_ROW;
                PS_ROW:  pass_q <= PS_VEC;
                default: state_q <= S_NXT;
              endcase
            end else begin
              i_q <= i_q + 2'd1;
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        S_NXT: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            if (sweep_q == SWW'(SWEEPS - 1)) begin
              state_q <= S_SR0;
            end else begin
              sweep_q <= sweep_q + SWW'(1);
              state_q <= S_CK0;
            end
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_PV0;
          end
        end
        S_SR0: state_q <= S_SR1;
        S_SR1: state_q <= S_SR2;
        S_SR2: begin
          bs_q    <= '0;
          state_q <= S_BS;
        end
        S_BS: begin
          if (bs_q == 2'd2) begin
            vj_q    <= '0;
            vk_q    <= '0;
            ph_q    <= '0;
            state_q <= S_VR;
          end else begin
            bs_q <= bs_q + 2'd1;
          end
        end
        S_VR: begin
          if (ph_q == 3'd0) begin
            ph_q <= 3'd1;
          end else begin
            ph_q <= '0;
            vec_q[vj_q][vk_q] <= sat_vec(rd_a);
            if (vk_q == 2'd2) begin
              vk_q <= '0;
              if (vj_q == 2'd2) begin
                eig_q[0] <= sat_eig(w0_q);
                eig_q[1] <= sat_eig(w1_q);
                eig_q[2] <= sat_eig(w2_q);
                done_q   <= 1'b1;
                state_q  <= S_OUT;
              end else begin
                vj_q <= vj_q + 2'd1;
              end
            end else begin
              vk_q <= vk_q + 2'd1;
            end
          end
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        in_q[0] <= MW'(a_00_i);
        in_q[1] <= MW'(a_01_i);
        in_q[2] <= MW'(a_02_i);
        in_q[3] <= MW'(a_11_i);
        in_q[4] <= MW'(a_12_i);
        in_q[5] <= MW'(a_22_i);
      end
      S_CK1: nz_q <= (rd_a != '0) || (rd_b != '0);
      S_PV1: begin
        apq_q <= rd_a;
        aqq_q <= rd_b;
      end
      S_PV2: begin
        md_q   <= dd[42] ? 43'(-dd) : 43'(dd);
        me_q   <= ee[42] ? 43'(-ee) : 43'(ee);
        tneg_q <= (dd != '0) && ((!dd[42]) != (!ee[42] && ee != '0));
      end
      S_SCL: begin
        if (md_q[42:31] != '0 || me_q[42:31] != '0) begin
          md_q <= md_q >> 1;
          me_q <= me_q >> 1;
        end
      end
      S_SQ1: acc_q <= mul_res;
      S_RT1: begin
        if (ds_done && den == '0) begin
          mt_q <= '0;
        end
      end
      S_DV1: begin
        if (ds_done) begin
          mt_q <= (ds_res > 64'h4000_0000) ? 31'h4000_0000 : ds_res[30:0];
        end
      end
      S_DV2: begin
        if (ds_done) begin
          c_q <= $signed({1'b0, ds_res[31:0]});
        end
      end
      S_SC1: s_q <= mul_res[32:0];
      S_UPD: begin
        unique case (ph_q)
          3'd1: begin
            xp_q <= rd_a;
            xq_q <= rd_b;
          end
          3'd3, 3'd5: pa_q <= mul_res;
          default: ;
        endcase
      end
      S_SR1: begin
        w0_q <= rd_a;
        w1_q <= rd_b;
      end
      S_SR2: begin
        w2_q  <= rd_a;
        pm0_q <= 2'd0;
        pm1_q <= 2'd1;
        pm2_q <= 2'd2;
      end
      S_BS: begin
        if (bs_swap) begin
          if (bs_q == 2'd1) begin
            w1_q  <= w2_q;
            w2_q  <= w1_q;
            pm1_q <= pm2_q;
            pm2_q <= pm1_q;
          end else begin
            w0_q  <= w1_q;
            w1_q  <= w0_q;
            pm0_q <= pm1_q;
            pm1_q <= pm0_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign eig_low_o  = eig_q[0];
  assign eig_mid_o  = eig_q[1];
  assign eig_high_o = eig_q[2];
  assign vec0_x_o   = vec_q[0][0];
  assign vec0_y_o   = vec_q[0][1];
  assign vec0_z_o   = vec_q[0][2];
  assign vec1_x_o   = vec_q[1][0];
  assign vec1_y_o   = vec_q[1][1];
  assign vec1_z_o   = vec_q[1][2];
  assign vec2_x_o   = vec_q[2][0];
  assign vec2_y_o   = vec_q[2][1];
  assign vec2_z_o   = vec_q[2][2];

endmodule

@@ hdl/sje_ram.sv @@
// ----------------------------------------------------------------------------
// sje_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sje_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_a_i,
  input  logic [$clog2(D)-1:0] raddr_b_i,
  output logic [W-1:0]         rdata_a_o,
  output logic [W-1:0]         rdata_b_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ hdl/sje_mul.sv @@
// ----------------------------------------------------------------------------
// sje_mul
// Shared multiplier. Gives x*y/2^30 rounded half away from zero, or the
// plain product, registered: it appears in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module sje_mul import sje_pkg::*; (
  input  logic                 clk_i,
  input  logic signed [MW-1:0] x_i,
  input  logic signed [32:0]   y_i,
  input  logic                 raw_i,
  output logic signed [63:0]   res_o
);

  logic [MW-1:0] mx;
  logic [32:0]   my_full;
  logic [31:0]   my;
  logic [61:0]   plo_q;
  logic [43:0]   phi_q;
  logic          neg_q;
  logic          raw_q;
  logic [63:0]   rq;
  logic [63:0]   rr;
  logic [63:0]   r;

  assign mx      = x_i[MW-1] ? -x_i : x_i;
  assign my_full = y_i[32] ? -y_i : y_i;
  assign my      = my_full[31:0];

  always_ff @(posedge clk_i) begin
    plo_q <= 62'(mx[29:0] * my);
    phi_q <= 44'(mx[MW-1:30] * my);
    neg_q <= x_i[MW-1] ^ y_i[32];
    raw_q <= raw_i;
  end

  assign rq    = {20'b0, phi_q} + (({2'b0, plo_q} + 64'h2000_0000) >> 30);
  assign rr    = ({20'b0, phi_q} << 30) + {2'b0, plo_q};
  assign r     = raw_q ? rr : rq;
  assign res_o = neg_q ? -$signed(r) : $signed(r);

endmodule

@@ hdl/sje_divsqrt.sv @@
// ----------------------------------------------------------------------------
// sje_divsqrt
// Shared iterative unit: 64-bit restoring divide (one quotient bit a cycle)
// or 64-bit integer square root (one result bit a cycle).
// ----------------------------------------------------------------------------
module sje_divsqrt import sje_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ds_req_t     req_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  ds_op_e      op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] dvs_q, dvs_d;
  logic [63:0] bit_q, bit_d;
  logic [64:0] trial;
  logic [63:0] sq_t;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    bit_d  = bit_q;
    trial  = {rem_q[63:0], acc_q[63]};
    sq_t   = acc_q + bit_q;
    if (req_i.start && !run_q) begin
      run_d = 1'b1;
      op_d  = req_i.op;
      unique case (req_i.op)
        DS_DIV: begin
          rem_d = '0;
          acc_d = a_i;
          dvs_d = b_i;
          cnt_d = 6'd63;
        end
        DS_SQRT: begin
          rem_d = {1'b0, a_i};
          acc_d = '0;
          bit_d = 64'h4000_0000_0000_0000;
          cnt_d = 6'd31;
        end
      endcase
    end else if (run_q) begin
      unique case (op_q)
        DS_DIV: begin
          if (trial >= {1'b0, dvs_q}) begin
            rem_d = trial - {1'b0, dvs_q};
            acc_d = {acc_q[62:0], 1'b1};
          end else begin
            rem_d = trial;
            acc_d = {acc_q[62:0], 1'b0};
          end
        end
        DS_SQRT: begin
          if (rem_q[63:0] >= sq_t) begin
            rem_d = {1'b0, rem_q[63:0] - sq_t};
            acc_d = (acc_q >> 1) + bit_q;
          end else begin
            acc_d = acc_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      endcase
      if (cnt_q == 6'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      op_q   <= DS_SQRT;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    dvs_q <= dvs_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

@@ hdl/sje_chk.sv @@
// ----------------------------------------------------------------------------
// sje_chk
// Port-level checks of the Jacobi eigen-solver, bound to the top level.
// ----------------------------------------------------------------------------
module sje_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [31:0] eig_low_o,
  input logic signed [31:0] eig_mid_o,
  input logic signed [31:0] eig_high_o,
  input logic signed [31:0] vec0_x_o
);

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("An accepted item did not raise busy.");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("A result strobe came while idle.");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("Busy or the strobe stayed after a result.");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> eig_low_o <= eig_mid_o && eig_mid_o <= eig_high_o)
    else $error("Eigenvalues are not in ascending order.");

  a_vec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> vec0_x_o <= 32'sd1073741824 && vec0_x_o >= -32'sd1073741824)
    else $error("An eigenvector component is out of range.");

endmodule

bind sym3_jacobi_eigen sje_chk u_sje_chk (.*);
